// ===== hdl/e2q_pkg.sv =====
`default_nettype none
package e2q_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int QUAT_BITS  = 16;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] roll_angle;
  } e2q_in_t;

  typedef struct packed {
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
  } e2q_out_t;

  // half-angle reduction steps needed beyond 16-bit angles
  localparam int RED_STEPS  = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
  localparam int MAG_W      = ANGLE_BITS + 17;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_LAT = RED_STEPS + 18;

  localparam int XW   = 34;  // cordic x, y, Q30
  localparam int ZW   = 35;  // residual angle, Q30
  localparam int TW   = 24;  // cos, sin, Q20
  localparam int PW   = 48;  // pair product, Q40
  localparam int TRIW = 64;  // triple product, Q60

  localparam logic [63:0] Q30_TWO_PI = 64'd6746518852;
  localparam logic signed [ZW-1:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_TWO_PI_S = 35'sd6746518852;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [XW-1:0] Q30_GAIN    = 34'sd652032874;

  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158, 35'sd67021686,
    35'sd33543515, 35'sd16775850, 35'sd8388437, 35'sd4194282, 35'sd2097149,
    35'sd1048575, 35'sd524287, 35'sd262143, 35'sd131071, 35'sd65535,
    35'sd32767, 35'sd16383, 35'sd8191, 35'sd4095, 35'sd2047,
    35'sd1023, 35'sd511, 35'sd255, 35'sd127, 35'sd63,
    35'sd31, 35'sd15, 35'sd7, 35'sd3, 35'sd1
  };

endpackage
`default_nettype wire

// ===== hdl/e2q_cordic.sv =====
`default_nettype none
module e2q_cordic (
  input  wire logic                                  clk_i,
  input  wire logic                                  en_i,
  input  wire logic signed [e2q_pkg::ANGLE_BITS-1:0] angle_i,
  output logic signed [e2q_pkg::TW-1:0]              cos_o,
  output logic signed [e2q_pkg::TW-1:0]              sin_o
);
  import e2q_pkg::*;

  logic [MAG_W-1:0] mag_q [RED_STEPS+1];
  logic             neg_q [RED_STEPS+1];

  // magnitude of half the angle in Q30, sign kept apart (truncating remainder)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= angle_i[ANGLE_BITS-1];
      mag_q[0] <= (angle_i[ANGLE_BITS-1] ? MAG_W'(-angle_i) : MAG_W'(angle_i)) << 17;
    end
  end

  for (genvar k = 1; k <= RED_STEPS; k++) begin : g_red
    localparam logic [63:0] SUB = Q30_TWO_PI << (RED_STEPS - k);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[k] <= neg_q[k-1];
        if (mag_q[k-1] >= SUB[MAG_W-1:0]) begin
          mag_q[k] <= mag_q[k-1] - SUB[MAG_W-1:0];
        end else begin
          mag_q[k] <= mag_q[k-1];
        end
      end
    end
  end

  logic signed [XW-1:0] x_q [CORDIC_STEPS/2+1];
  logic signed [XW-1:0] y_q [CORDIC_STEPS/2+1];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS/2+1];
  logic                 flip_q [CORDIC_STEPS/2+1];

  logic [MAG_W+ZW-1:0]  mag_x;
  logic signed [ZW-1:0] r0, r1, r2;
  logic                 flip_d;

  // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    mag_x = (MAG_W+ZW)'(mag_q[RED_STEPS]);
    r0 = $signed({1'b0, mag_x[ZW-2:0]});
    if (neg_q[RED_STEPS]) r0 = -r0;
    r1 = r0;
    if (r0 > Q30_PI) r1 = r0 - Q30_TWO_PI_S;
    else if (r0 < -Q30_PI) r1 = r0 + Q30_TWO_PI_S;
    r2 = r1;
    flip_d = 1'b0;
    if (r1 > Q30_HALF_PI) begin
      r2 = r1 - Q30_PI;
      flip_d = 1'b1;
    end else if (r1 < -Q30_HALF_PI) begin
      r2 = r1 + Q30_PI;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= Q30_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= r2;
      flip_q[0] <= flip_d;
    end
  end

  // two rotations per stage
  for (genvar j = 0; j < CORDIC_STEPS/2; j++) begin : g_rot
    logic signed [XW-1:0] xa, ya, xb, yb;
    logic signed [ZW-1:0] za, zb;
    always_comb begin
      if (!z_q[j][ZW-1]) begin
        xa = x_q[j] - (y_q[j] >>> (2*j));
        ya = y_q[j] + (x_q[j] >>> (2*j));
        za = z_q[j] - ATAN_TAB[2*j];
      end else begin
        xa = x_q[j] + (y_q[j] >>> (2*j));
        ya = y_q[j] - (x_q[j] >>> (2*j));
        za = z_q[j] + ATAN_TAB[2*j];
      end
      if (!za[ZW-1]) begin
        xb = xa - (ya >>> (2*j+1));
        yb = ya + (xa >>> (2*j+1));
        zb = za - ATAN_TAB[2*j+1];
      end else begin
        xb = xa + (ya >>> (2*j+1));
        yb = ya - (xa >>> (2*j+1));
        zb = za + ATAN_TAB[2*j+1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[j+1]    <= xb;
        y_q[j+1]    <= yb;
        z_q[j+1]    <= zb;
        flip_q[j+1] <= flip_q[j];
      end
    end
  end

  logic [XW-1:0] cm, sm;
  logic [XW-1:0] cr, sr;
  logic          cn, sn;

  // Q30 to Q20, half away from zero, with the fold sign applied
  always_comb begin
    cn = x_q[CORDIC_STEPS/2][XW-1] ^ flip_q[CORDIC_STEPS/2];
    sn = y_q[CORDIC_STEPS/2][XW-1] ^ flip_q[CORDIC_STEPS/2];
    cm = x_q[CORDIC_STEPS/2][XW-1] ? XW'(-x_q[CORDIC_STEPS/2]) : XW'(x_q[CORDIC_STEPS/2]);
    sm = y_q[CORDIC_STEPS/2][XW-1] ? XW'(-y_q[CORDIC_STEPS/2]) : XW'(y_q[CORDIC_STEPS/2]);
    cr = (cm + XW'(512)) >> 10;
    sr = (sm + XW'(512)) >> 10;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= cn ? -$signed(cr[TW-1:0]) : $signed(cr[TW-1:0]);
      sin_o <= sn ? -$signed(sr[TW-1:0]) : $signed(sr[TW-1:0]);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/euler_to_quaternion_core.sv =====
`default_nettype none
// ZYX euler angles to unit quaternion.
// input beat: yaw, pitch and roll in radians with 12 fraction bits.
// output beat: quaternion w, x, y, z with 14 fraction bits, rounded and
// clamped to +-16384.
// both channels use valid/stall; a beat moves when valid is high and
// stall is low.
// one beat is taken every cycle while the pipeline is not stalled; a beat
// passes the pipelined half-angle cordic, the two multiply stages, the
// sums and the rounding output register, plus the range-reduction steps
// for angle bits above 16.
// when the receiver stalls a valid result, the whole pipeline holds and
// the input channel is stalled in the same cycle; nothing is dropped.
// reset clears the valid bits only; the data registers are not reset.
module euler_to_quaternion_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire e2q_pkg::e2q_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output e2q_pkg::e2q_out_t      out_data_o
);
  import e2q_pkg::*;

  localparam int LAT = CORDIC_LAT + 4;
  localparam longint HI_L = (64'sd1 <<< (QUAT_BITS-1)) - 1;
  localparam longint SAT_HI = (HI_L > 16384) ? 16384 : HI_L;
  localparam longint SAT_LO = (-(64'sd1 <<< (QUAT_BITS-1)) < -16384) ? -16384
                              : -(64'sd1 <<< (QUAT_BITS-1));

  logic en;
  logic [LAT-1:0] vld_q;

  assign en          = !vld_q[LAT-1] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  logic signed [TW-1:0] cy, sy, cp, sp, cr, sr;

  e2q_cordic u_yaw   (.clk_i, .en_i(en), .angle_i(in_data_i.yaw_angle),   .cos_o(cy), .sin_o(sy));
  e2q_cordic u_pitch (.clk_i, .en_i(en), .angle_i(in_data_i.pitch_angle), .cos_o(cp), .sin_o(sp));
  e2q_cordic u_roll  (.clk_i, .en_i(en), .angle_i(in_data_i.roll_angle),  .cos_o(cr), .sin_o(sr));

  logic signed [PW-1:0]   cc_q, ss_q, sc_q, cs_q;
  logic signed [TW-1:0]   cy_q, sy_q;
  logic signed [TRIW-1:0] th_q [8];
  logic signed [TRIW-1:0] tl_q [8];
  logic signed [TRIW-1:0] sum_q [4];

  // pair product split into a signed upper and an unsigned lower half
  function automatic logic signed [TRIW-1:0] mul_hi(logic signed [PW-1:0] a,
                                                    logic signed [TW-1:0] b);
    return TRIW'($signed(a[PW-1:PW-TW]) * b);
  endfunction

  function automatic logic signed [TRIW-1:0] mul_lo(logic signed [PW-1:0] a,
                                                    logic signed [TW-1:0] b);
    return TRIW'($signed({1'b0, a[PW-TW-1:0]}) * b);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      cc_q <= PW'(cr * cp);
      ss_q <= PW'(sr * sp);
      sc_q <= PW'(sr * cp);
      cs_q <= PW'(cr * sp);
      cy_q <= cy;
      sy_q <= sy;
      th_q[0] <= mul_hi(cc_q, cy_q);
      tl_q[0] <= mul_lo(cc_q, cy_q);
      th_q[1] <= mul_hi(ss_q, sy_q);
      tl_q[1] <= mul_lo(ss_q, sy_q);
      th_q[2] <= mul_hi(sc_q, cy_q);
      tl_q[2] <= mul_lo(sc_q, cy_q);
      th_q[3] <= mul_hi(cs_q, sy_q);
      tl_q[3] <= mul_lo(cs_q, sy_q);
      th_q[4] <= mul_hi(cs_q, cy_q);
      tl_q[4] <= mul_lo(cs_q, cy_q);
      th_q[5] <= mul_hi(sc_q, sy_q);
      tl_q[5] <= mul_lo(sc_q, sy_q);
      th_q[6] <= mul_hi(cc_q, sy_q);
      tl_q[6] <= mul_lo(cc_q, sy_q);
      th_q[7] <= mul_hi(ss_q, cy_q);
      tl_q[7] <= mul_lo(ss_q, cy_q);
      sum_q[0] <= (th_q[0] <<< (PW-TW)) + tl_q[0] + (th_q[1] <<< (PW-TW)) + tl_q[1];
      sum_q[1] <= (th_q[2] <<< (PW-TW)) + tl_q[2] - (th_q[3] <<< (PW-TW)) - tl_q[3];
      sum_q[2] <= (th_q[4] <<< (PW-TW)) + tl_q[4] + (th_q[5] <<< (PW-TW)) + tl_q[5];
      sum_q[3] <= (th_q[6] <<< (PW-TW)) + tl_q[6] - (th_q[7] <<< (PW-TW)) - tl_q[7];
    end
  end

  logic signed [QUAT_BITS-1:0] q_d [4];

  // Q60 to Q14, half away from zero, then clamp
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      logic [TRIW-1:0] m;
      logic signed [TRIW-1:0] v;
      m = sum_q[n][TRIW-1] ? TRIW'(-sum_q[n]) : TRIW'(sum_q[n]);
      m = (m + (TRIW'(1) << 45)) >> 46;
      v = sum_q[n][TRIW-1] ? -$signed(m) : $signed(m);
      if (v > SAT_HI) v = SAT_HI;
      if (v < SAT_LO) v = SAT_LO;
      q_d[n] = v[QUAT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o.quat_w <= q_d[0];
      out_data_o.quat_x <= q_d[1];
      out_data_o.quat_y <= q_d[2];
      out_data_o.quat_z <= q_d[3];
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import e2q_pkg::*;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam int     ANGLE_MAX   = 25736;
  localparam int     LATENCY     = 22;

  longint arctan_q30 [30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149,
    1048575, 524287, 262143, 131071, 65535,
    32767, 16383, 8191, 4095, 2047,
    1023, 511, 255, 127, 63,
    31, 15, 7, 3, 1
  };

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  e2q_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  e2q_out_t out_data;

  e2q_in_t  pending_angles[$];
  e2q_out_t expected_quats[$];
  int       mismatch_count;
  int       gap_left;
  int       burst_left;
  int       hold_off_left;
  int       stall_phase;
  bit       long_hold_request;

  euler_to_quaternion_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_away(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  // cosine and sine of half the angle, Q20
  task automatic half_angle_trig(input logic signed [15:0] angle,
                                 output longint c, output longint s);
    longint r, x, y, nx;
    bit     flip;
    r = (longint'(angle) * 131072) % TWO_PI_Q30;
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (r > PI_Q30) r -= TWO_PI_Q30;
    if (r < -PI_Q30) r += TWO_PI_Q30;
    if (r > HALF_PI_Q30) begin
      r -= PI_Q30;
      flip = 1'b1;
    end else if (r < -HALF_PI_Q30) begin
      r += PI_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        r -= arctan_q30[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        r += arctan_q30[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = round_away(x, 10);
    s = round_away(y, 10);
  endtask

  function automatic logic signed [15:0] to_q14(longint q60);
    longint v;
    v = round_away(q60, 46);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return 16'(v);
  endfunction

  task automatic predict_quaternion(input e2q_in_t a);
    longint cy, sy, cp, sp, cr, sr;
    e2q_out_t q;
    half_angle_trig(a.yaw_angle, cy, sy);
    half_angle_trig(a.pitch_angle, cp, sp);
    half_angle_trig(a.roll_angle, cr, sr);
    q.quat_w = to_q14(cr * cp * cy + sr * sp * sy);
    q.quat_x = to_q14(sr * cp * cy - cr * sp * sy);
    q.quat_y = to_q14(cr * sp * cy + sr * cp * sy);
    q.quat_z = to_q14(cr * cp * sy - sr * sp * cy);
    expected_quats.push_back(q);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic signed [15:0] any_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom());
    if (r == 1) return 16'(ANGLE_MAX - int'($urandom_range(0, 8)));
    if (r == 2) return 16'(-ANGLE_MAX + int'($urandom_range(0, 8)));
    return 16'(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
  endfunction

  // sender: bursts with random gaps
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      gap_left   <= 0;
      burst_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_quaternion(in_data);
        void'(pending_angles.pop_front());
      end
      if (gap_left > 0 || pending_angles.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending_angles[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall     <= 1'b0;
      hold_off_left <= 0;
      stall_phase   <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (long_hold_request && hold_off_left == 0) begin
        hold_off_left <= 80;
        out_stall     <= 1'b1;
      end else if (hold_off_left > 1) begin
        hold_off_left <= hold_off_left - 1;
      end else if (stall_phase[9:8] == 2'b00) begin
        hold_off_left <= 0;
        out_stall     <= 1'b0;
      end else begin
        hold_off_left <= 0;
        out_stall     <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        e2q_out_t want;
        want = expected_quats.pop_front();
        if (out_data.quat_w !== want.quat_w)
          report_mismatch("quat_w", out_data.quat_w, want.quat_w);
        if (out_data.quat_x !== want.quat_x)
          report_mismatch("quat_x", out_data.quat_x, want.quat_x);
        if (out_data.quat_y !== want.quat_y)
          report_mismatch("quat_y", out_data.quat_y, want.quat_y);
        if (out_data.quat_z !== want.quat_z)
          report_mismatch("quat_z", out_data.quat_z, want.quat_z);
      end
    end
  end

  initial begin
    e2q_in_t a;
    logic signed [15:0] edge_vals [10] = '{0, 1, -1, 16'sh7fff, 16'sh8000,
      16'(ANGLE_MAX), 16'(-ANGLE_MAX), 6434, -6434, 12868};
    mismatch_count    = 0;
    long_hold_request = 1'b0;
    rst_n = 1'b0;
    for (int i = 0; i < 10; i++) begin
      a.yaw_angle   = edge_vals[i];
      a.pitch_angle = edge_vals[(i + 3) % 10];
      a.roll_angle  = edge_vals[(i + 7) % 10];
      pending_angles.push_back(a);
    end
    for (int i = 0; i < 10; i++) begin
      a = '0;
      a.yaw_angle = edge_vals[i];
      pending_angles.push_back(a);
    end
    a.yaw_angle = 3217; a.pitch_angle = 6434; a.roll_angle = -3217;
    pending_angles.push_back(a);
    for (int i = 0; i < 1030; i++) begin
      a.yaw_angle   = any_angle();
      a.pitch_angle = any_angle();
      a.roll_angle  = any_angle();
      pending_angles.push_back(a);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (300) @(posedge clk);
    // receiver holds off while the sender keeps offering
    long_hold_request <= 1'b1;
    @(posedge clk);
    long_hold_request <= 1'b0;
    while (pending_angles.size() != 0 || in_valid) @(posedge clk);
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0 && expected_quats.size() == 0)
      $display("euler_to_quaternion_core: match");
    else
      $display("euler_to_quaternion_core: mismatch");
    $finish;
  end

  initial begin
    #2ms;
    $display("euler_to_quaternion_core: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
